// ----- sv/hduart_pkg.sv -----
// ----------------------------------------------------------------------------
// hduart_pkg
// Shared widths, reset values, line modes and the result layout for the
// half-duplex 8N1 serial core.
// ----------------------------------------------------------------------------
package hduart_pkg;

   localparam int BYTE_W          = 8;
   localparam int CFG_W           = 16;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 16;
   localparam int BIT_IDX_W       = 4;
   localparam int DATA_BITS_DEF   = 8;
   localparam int TICK_WIDTH_DEF  = 16;

   localparam logic [CFG_W-1:0] BIT_TICKS_RESET = 16'd104;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_TX   = 3'b010,
      MODE_RX   = 3'b100
   } mode_type;

   // first field in the highest bit
   typedef struct packed {
      logic              send_refused;
      logic              frame_error;
      logic [BYTE_W-1:0] rx_data;
      logic              rx_valid;
      logic              rx_busy;
      logic              tx_busy;
      logic              tx_pin;
   } rsp_fields_type;

   localparam int RSP_FIELDS_W = $bits(rsp_fields_type);

endpackage

// ----- sv/half_duplex_uart_8n1_core.sv -----
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1_core
// Half-duplex 8N1 serial port, advanced by one timer tick per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each req beat is one timer tick. req_tuser set asks to send the byte in
//   req_tdata[7:0]; req_tdata[8] is the sampled receive line. Each req beat
//   yields exactly one rsp beat with the transmit level, busy flags, any
//   received byte with its frame error, and a refused-send flag.
//   csr_data sets the ticks per bit period; write it only while idle.
//   csr_ready is always high.
// Registers and throughput:
//   A beat passes an input register and then a result register before it
//   shows on rsp_tvalid. One beat per cycle is sustained while rsp_tready
//   stays high; the state update between the two registers is combinational.
// Reset:
//   Line idle, transmit level high, ticks per bit 104, both registers empty.
// Stall:
//   While rsp_tready is low the result holds, one more beat waits in the
//   input register, and req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1_core #(
   parameter int DATA_BITS  = hduart_pkg::DATA_BITS_DEF,
   parameter int TICK_WIDTH = hduart_pkg::TICK_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hduart_pkg::REQ_DATA_W-1:0] req_tdata,  // send_byte, rx_pin
   input  logic                             req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tx_pin, tx_busy, rx_busy, rx_valid, rx_data, frame_error, send_refused
   output logic [hduart_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hduart_pkg::CFG_W-1:0]      csr_data
);
   import hduart_pkg::*;

   localparam int CMP_W = ((TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W) + 1;

   logic                     in_valid_ff, in_valid_in;
   logic                     in_req_ff;
   logic [BYTE_W-1:0]        in_byte_ff;
   logic                     in_pin_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_fields_type           rsp_ff, rsp_in;
   logic [CFG_W-1:0]         bit_ticks_ff;

   mode_type                 mode_ff, mode_in;
   logic [TICK_WIDTH-1:0]    count_ff, count_in;
   logic [BIT_IDX_W-1:0]     idx_ff, idx_in;
   logic [BYTE_W-1:0]        tx_shift_ff, tx_shift_in;
   logic [BYTE_W-1:0]        rx_shift_ff, rx_shift_in;
   logic                     last_rx_ff;
   logic                     tx_level_ff, tx_level_in;

   logic                     out_adv;
   logic                     fire;
   logic [CMP_W-1:0]         cnt_next;
   logic [CMP_W-1:0]         limit;
   logic                     done;
   logic                     edge_seen;
   logic [BIT_IDX_W-1:0]     idx_inc;
   logic [BIT_IDX_W-1:0]     tx_sel;
   logic [BIT_IDX_W-1:0]     rx_sel;

   assign out_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !in_valid_ff || out_adv;
   assign fire        = in_valid_ff && out_adv;
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {(RSP_DATA_W - RSP_FIELDS_W)'(0), rsp_ff};

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = out_adv ? in_valid_ff : rsp_valid_ff;

   assign cnt_next  = CMP_W'(count_ff) + CMP_W'(1);
   assign edge_seen = last_rx_ff && !in_pin_ff;
   assign idx_inc   = idx_ff + BIT_IDX_W'(1);
   assign tx_sel    = idx_inc - BIT_IDX_W'(1);
   assign rx_sel    = idx_ff - BIT_IDX_W'(1);

   always_comb begin
      limit = CMP_W'(bit_ticks_ff);
      if (mode_ff == MODE_RX && idx_ff == '0) begin
         limit = CMP_W'(bit_ticks_ff >> 1);
      end
   end

   assign done = (cnt_next >= limit) || cnt_next[TICK_WIDTH];

   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      tx_shift_in = tx_shift_ff;
      rx_shift_in = rx_shift_ff;
      tx_level_in = tx_level_ff;
      rsp_in      = '0;
      unique case (mode_ff)
         MODE_TX: begin
            rsp_in.send_refused = in_req_ff;
            count_in = done ? '0 : cnt_next[TICK_WIDTH-1:0];
            if (done) begin
               idx_in = idx_inc;
               if (idx_inc >= BIT_IDX_W'(1) && idx_inc <= BIT_IDX_W'(DATA_BITS)) begin
                  tx_level_in = tx_shift_ff[tx_sel[2:0]];
               end else if (idx_inc == BIT_IDX_W'(DATA_BITS + 1)) begin
                  tx_level_in = 1'b1;
               end else begin
                  tx_level_in = 1'b1;
                  mode_in     = MODE_IDLE;
                  idx_in      = '0;
                  tx_shift_in = '0;
               end
            end
         end
         MODE_RX: begin
            rsp_in.send_refused = in_req_ff;
            count_in = done ? '0 : cnt_next[TICK_WIDTH-1:0];
            if (done) begin
               if (idx_ff == '0) begin
                  idx_in = BIT_IDX_W'(1);
               end else if (idx_ff <= BIT_IDX_W'(DATA_BITS)) begin
                  rx_shift_in[rx_sel[2:0]] = in_pin_ff;
                  idx_in = idx_inc;
               end else begin
                  rsp_in.rx_valid    = 1'b1;
                  rsp_in.rx_data     = rx_shift_ff;
                  rsp_in.frame_error = !in_pin_ff;
                  mode_in            = MODE_IDLE;
                  idx_in             = '0;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (edge_seen) begin
               rsp_in.send_refused = in_req_ff;
               mode_in     = MODE_RX;
               count_in    = '0;
               idx_in      = '0;
               rx_shift_in = '0;
            end else if (in_req_ff) begin
               mode_in     = MODE_TX;
               count_in    = '0;
               idx_in      = '0;
               tx_shift_in = in_byte_ff;
               tx_level_in = 1'b0;
            end
         end
      endcase
      rsp_in.tx_pin  = tx_level_in;
      rsp_in.tx_busy = (mode_in == MODE_TX);
      rsp_in.rx_busy = (mode_in == MODE_RX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bit_ticks_ff <= BIT_TICKS_RESET;
         mode_ff      <= MODE_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         tx_shift_ff  <= '0;
         rx_shift_ff  <= '0;
         last_rx_ff   <= 1'b1;
         tx_level_ff  <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            bit_ticks_ff <= csr_data;
         end
         if (fire) begin
            mode_ff     <= mode_in;
            count_ff    <= count_in;
            idx_ff      <= idx_in;
            tx_shift_ff <= tx_shift_in;
            rx_shift_ff <= rx_shift_in;
            last_rx_ff  <= in_pin_ff;
            tx_level_ff <= tx_level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_req_ff  <= req_tuser;
         in_byte_ff <= req_tdata[BYTE_W-1:0];
         in_pin_ff  <= req_tdata[BYTE_W];
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/hduart_checker.sv -----
// ----------------------------------------------------------------------------
// hduart_checker
// Port-level checks for the half-duplex 8N1 serial core, bound to the top.
// ----------------------------------------------------------------------------
module hduart_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hduart_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hduart_pkg::*;

   rsp_fields_type rsp;
   assign rsp = rsp_tdata[RSP_FIELDS_W-1:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.tx_busy && rsp.rx_busy))
      else $error("send and receive busy together");

   a_byte_ends_rx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.rx_valid |-> !rsp.rx_busy && !rsp.tx_busy)
      else $error("line still busy on received byte");

   a_ferr_with_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.frame_error |-> rsp.rx_valid)
      else $error("frame error without received byte");

   a_tx_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.tx_busy |-> rsp.tx_pin)
      else $error("transmit line low while not sending");

endmodule

bind half_duplex_uart_8n1_core hduart_checker u_hduart_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/half_duplex_uart_8n1_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1_core_tb
// Drives the serial core one timer tick per req beat. Each beat is run
// through a local line model that predicts the rsp beat it causes. Every rsp
// beat is checked against that prediction.
// The stimulus covers:
//   - transmit frames, and send requests while the line is busy;
//   - receive frames with good and bad stop bits;
//   - line glitches and random bit periods;
//   - short bit periods and the longest bit period.
// Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1_core_tb;
   import hduart_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int unsigned TICK_MAX    = (1 << TICK_WIDTH_DEF) - 1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // send_byte, rx_pin
   logic                  req_tuser;   // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // tx_pin, tx_busy, rx_busy, rx_valid, rx_data, frame_error, send_refused
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data;

   // line model state
   logic [CFG_W-1:0]     bit_ticks_cfg;
   mode_type             line_mode;
   int unsigned          tick_cnt;
   logic [BIT_IDX_W-1:0] bit_pos;
   logic [BYTE_W-1:0]    tx_hold;
   logic [BYTE_W-1:0]    rx_hold;
   bit                   prev_pin;
   bit                   tx_line;

   rsp_fields_type line_status_q[$];
   int             beats_sent;
   int             beats_seen = 0;
   int             err_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct;
   int             recv_stall_pct;

   half_duplex_uart_8n1_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("half_duplex_uart_8n1_core_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   function automatic bit period_end(int unsigned span);
      int unsigned nxt;
      nxt = tick_cnt + 1;
      if (nxt >= span || nxt > TICK_MAX) begin
         tick_cnt = 0;
         return 1'b1;
      end
      tick_cnt = nxt;
      return 1'b0;
   endfunction

   function automatic rsp_fields_type uart_tick(bit want_send, logic [BYTE_W-1:0] tx_byte,
                                                bit pin);
      rsp_fields_type r;
      bit             fell;
      int unsigned    span;
      r    = '0;
      fell = prev_pin && !pin;
      if (line_mode == MODE_TX) begin
         r.send_refused = want_send;
         if (period_end(32'(bit_ticks_cfg))) begin
            bit_pos = bit_pos + 1'b1;
            if (bit_pos >= 1 && bit_pos <= DATA_BITS_DEF) begin
               tx_line = tx_hold[bit_pos-1];
            end else if (bit_pos == DATA_BITS_DEF + 1) begin
               tx_line = 1'b1;
            end else begin
               tx_line   = 1'b1;
               line_mode = MODE_IDLE;
               bit_pos   = '0;
               tx_hold   = '0;
            end
         end
      end else if (line_mode == MODE_RX) begin
         r.send_refused = want_send;
         span = 32'((bit_pos == 0) ? (bit_ticks_cfg >> 1) : bit_ticks_cfg);
         if (period_end(span)) begin
            if (bit_pos == 0) begin
               bit_pos = BIT_IDX_W'(1);
            end else if (bit_pos <= DATA_BITS_DEF) begin
               rx_hold[bit_pos-1] = pin;
               bit_pos = bit_pos + 1'b1;
            end else begin
               r.rx_valid    = 1'b1;
               r.rx_data     = rx_hold;
               r.frame_error = !pin;
               line_mode     = MODE_IDLE;
               bit_pos       = '0;
            end
         end
      end else begin
         line_mode = MODE_IDLE;
         if (fell) begin
            r.send_refused = want_send;
            line_mode = MODE_RX;
            tick_cnt  = 0;
            bit_pos   = '0;
            rx_hold   = '0;
         end else if (want_send) begin
            line_mode = MODE_TX;
            tick_cnt  = 0;
            bit_pos   = '0;
            tx_hold   = tx_byte;
            tx_line   = 1'b0;
         end
      end
      prev_pin   = pin;
      r.tx_pin   = tx_line;
      r.tx_busy  = (line_mode == MODE_TX);
      r.rx_busy  = (line_mode == MODE_RX);
      return r;
   endfunction

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      rsp_fields_type want;
      rsp_fields_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_fields_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
         if (line_status_q.size() == 0) begin
            flag_error($sformatf("rsp beat %0d: no beat expected, got %h",
                                 beats_seen, rsp_tdata));
         end else begin
            want = line_status_q.pop_front();
            if (rsp_tdata !== {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, want}) begin
               flag_error($sformatf({"rsp beat %0d: expected/actual tx_pin %b/%b ",
                  "tx_busy %b/%b rx_busy %b/%b rx_valid %b/%b rx_data %h/%h ",
                  "frame_error %b/%b send_refused %b/%b tdata %h/%h"}, beats_seen,
                  want.tx_pin, got.tx_pin, want.tx_busy, got.tx_busy,
                  want.rx_busy, got.rx_busy, want.rx_valid, got.rx_valid,
                  want.rx_data, got.rx_data, want.frame_error, got.frame_error,
                  want.send_refused, got.send_refused,
                  {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, want}, rsp_tdata));
            end
         end
         beats_seen++;
      end
   end

   task automatic send_tick(input bit want_send, input logic [BYTE_W-1:0] tx_byte,
                            input bit pin);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= want_send;
      req_tdata  <= {{(REQ_DATA_W-BYTE_W-1){1'b0}}, pin, tx_byte};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      line_status_q.push_back(uart_tick(want_send, tx_byte, pin));
      beats_sent++;
   endtask

   task automatic settle_line();
      while (line_mode != MODE_IDLE || !prev_pin) send_tick(1'b0, BYTE_W'($urandom), 1'b1);
   endtask

   task automatic set_bit_ticks(input logic [CFG_W-1:0] value);
      settle_line();
      req_tvalid <= 1'b0;
      while (line_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      bit_ticks_cfg  = value;
   endtask

   task automatic transmit_frame(input logic [BYTE_W-1:0] data, input int send_pct,
                                 input int glitch_pct);
      settle_line();
      send_tick(1'b1, data, 1'b1);
      while (line_mode == MODE_TX) begin
         send_tick($urandom_range(99, 0) < send_pct, BYTE_W'($urandom),
                   $urandom_range(99, 0) >= glitch_pct);
      end
   endtask

   task automatic receive_frame(input logic [BYTE_W-1:0] data, input bit stop_level,
                                input bit send_on_edge, input int send_pct);
      int span;
      int k;
      bit lvl;
      bit want;
      settle_line();
      span = int'(bit_ticks_cfg);
      for (int i = 0; i < 10 * span; i++) begin
         k    = i / span;
         lvl  = (k == 0) ? 1'b0 : (k <= DATA_BITS_DEF) ? data[k-1] : stop_level;
         want = (i == 0) ? send_on_edge
                         : (line_mode == MODE_RX && $urandom_range(99, 0) < send_pct);
         send_tick(want, BYTE_W'($urandom), lvl);
      end
   endtask

   task automatic line_noise(input int count);
      repeat (count) begin
         send_tick($urandom_range(99, 0) < 10, BYTE_W'($urandom),
                   $urandom_range(99, 0) >= 35);
      end
   endtask

   task automatic run_traffic(input int beats);
      int target;
      int pick;
      target = beats_sent + beats;
      while (beats_sent < target) begin
         pick = $urandom_range(99, 0);
         if (pick < 38) begin
            transmit_frame(BYTE_W'($urandom), $urandom_range(30, 0), $urandom_range(40, 0));
         end else if (pick < 80) begin
            receive_frame(BYTE_W'($urandom), $urandom_range(99, 0) < 85,
                          $urandom_range(99, 0) < 10, $urandom_range(30, 0));
         end else if (pick < 92) begin
            line_noise($urandom_range(12, 1));
         end else begin
            repeat ($urandom_range(5, 1)) send_tick(1'b0, BYTE_W'($urandom), 1'b1);
         end
      end
      settle_line();
   endtask

   task automatic test_reset_idle();
      repeat (4) send_tick(1'b0, BYTE_W'($urandom), 1'b1);
   endtask

   task automatic test_transmit();
      set_bit_ticks(16'd2);
      transmit_frame(8'h00, 100, 50);
      transmit_frame(8'hFF, 0, 0);
   endtask

   task automatic test_receive();
      receive_frame(8'h00, 1'b0, 1'b1, 100);
      receive_frame(8'hFF, 1'b1, 1'b0, 0);
      receive_frame(8'h5A, 1'b1, 1'b0, 50);
   endtask

   task automatic test_random_traffic();
      send_idle_pct  = 17;
      recv_stall_pct = 68;
      set_bit_ticks(16'd2);
      run_traffic(200);
      set_bit_ticks(16'd5);
      run_traffic(200);
      send_idle_pct  = 68;
      recv_stall_pct = 17;
      set_bit_ticks(16'd3);
      run_traffic(200);
      set_bit_ticks(CFG_W'($urandom_range(12, 2)));
      run_traffic(200);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_bit_ticks(CFG_W'($urandom_range(24, 16)));
      run_traffic(150);
      set_bit_ticks(CFG_W'($urandom_range(8, 4)));
      run_traffic(150);
   endtask

   task automatic test_slowest_rate();
      set_bit_ticks(16'hFFFF);
      send_tick(1'b1, BYTE_W'($urandom), 1'b1);
      repeat (200) begin
         send_tick($urandom_range(99, 0) < 20, BYTE_W'($urandom),
                   1'($urandom_range(1, 0)));
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= 1'b0;
      csr_valid      <= 1'b0;
      csr_data       <= '0;
      beats_sent      = 0;
      send_idle_pct   = 17;
      recv_stall_pct  = 68;
      bit_ticks_cfg   = BIT_TICKS_RESET;
      line_mode       = MODE_IDLE;
      tick_cnt        = 0;
      bit_pos         = '0;
      tx_hold         = '0;
      rx_hold         = '0;
      prev_pin        = 1'b1;
      tx_line         = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_idle();
      test_transmit();
      test_receive();
      test_random_traffic();
      test_slowest_rate();

      req_tvalid <= 1'b0;
      while (line_status_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("half_duplex_uart_8n1_core_tb OK");
      end else begin
         $display("half_duplex_uart_8n1_core_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/hduart_pkg.sv
sv/half_duplex_uart_8n1_core.sv
sv/hduart_checker.sv
bench/half_duplex_uart_8n1_core_tb.sv
